// ===== rtl/bclm_pkg.sv =====
package bclm_pkg;

  // Request kinds carried in the kind field.
  typedef enum logic [2:0] {
    KIND_SET  = 3'd0,
    KIND_AND  = 3'd1,
    KIND_OR   = 3'd2,
    KIND_XOR  = 3'd3,
    KIND_SWAP = 3'd4,
    KIND_TICK = 3'd5
  } kind_t;

  // Colour plane selects.
  localparam logic [1:0] PLANE_RED   = 2'b01;
  localparam logic [1:0] PLANE_GREEN = 2'b10;

  typedef logic [7:0] pixel_row_t;

endpackage

// ===== rtl/bicolor_led_matrix_scanner.sv =====
// Bicolour LED matrix scanner with two buffered row stores.
// Input channel (in_valid / in_stall) carries one request per cycle when not
// stalled: set a row of the drawing buffer, AND, OR or XOR a mask into it,
// swap the drawing and shown buffers, or give one scan tick. Colour bit 0
// picks the red plane, bit 1 the green plane. Only a scan tick produces a
// result on the output channel (out_valid / out_stall): the active-low row
// select, the bit-reversed green and red column bytes of the shown row, its
// index and a frame-end mark. A request is captured in the input register and
// processed, by one row read-modify-write or row readout, as it leaves that
// register; a tick result is loaded into the output register then, so
// out_valid rises in the cycle after the tick leaves the input register.
// When the receiver stalls, the output register holds its result; further
// non-tick requests still flow, and a second tick waits in the input register,
// which raises in_stall until the output is taken.
// Reset clears both row stores, shows buffer one, draws into buffer zero and
// restarts the scan at row zero; both channels come out of reset empty.
module bicolor_led_matrix_scanner import bclm_pkg::*; #(
  parameter int ROWS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [2:0] row,
  input  logic [7:0] value,
  input  logic [1:0] colour,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] row_select,
  output logic [7:0] green_columns,
  output logic [7:0] red_columns,
  output logic [2:0] row_index,
  output logic       frame_end
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Row stores, indexed by buffer then row.
  pixel_row_t green_store [2][ROWS];
  pixel_row_t red_store   [2][ROWS];
  logic       shown;
  logic [RW-1:0] scan_row;

  // Input register.
  logic       s1_valid;
  kind_t      s1_kind;
  logic [2:0] s1_row;
  logic [7:0] s1_value;
  logic [1:0] s1_colour;

  logic s1_tick;
  logic s1_advance;
  logic s1_modify;
  logic row_ok;
  logic [4:0] row_ext;
  logic [4:0] scan_ext;
  logic [RW-1:0] rd_row;
  logic rd_buf;
  pixel_row_t green_rd, red_rd;
  pixel_row_t green_new, red_new;
  logic [7:0] sel_next;
  logic frame_next;
  logic [RW-1:0] scan_row_next;

  function automatic pixel_row_t combine(kind_t k, pixel_row_t old, pixel_row_t v);
    pixel_row_t r;
    case (k)
      KIND_SET: r = v;
      KIND_AND: r = old & v;
      KIND_OR:  r = old | v;
      default:  r = old ^ v;
    endcase
    return r;
  endfunction

  function automatic pixel_row_t reverse_byte(pixel_row_t b);
    pixel_row_t r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  // Handshake: a non-tick request always drains; a tick needs the output slot.
  assign s1_tick    = s1_valid && (s1_kind == KIND_TICK);
  assign s1_advance = s1_valid && (!s1_tick || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  // Row addressing and the single store read port.
  always_comb begin
    row_ext   = {2'b00, s1_row};
    scan_ext  = 5'(scan_row);
    row_ok    = row_ext < 5'(ROWS);
    s1_modify = (s1_kind inside {KIND_SET, KIND_AND, KIND_OR, KIND_XOR}) && row_ok;
    if (s1_kind == KIND_TICK) begin
      rd_buf = shown;
      rd_row = scan_row;
    end else begin
      rd_buf = !shown;
      rd_row = row_ext[RW-1:0];
    end
    green_rd  = green_store[rd_buf][rd_row];
    red_rd    = red_store[rd_buf][rd_row];
    green_new = combine(s1_kind, green_rd, s1_value);
    red_new   = combine(s1_kind, red_rd, s1_value);
  end

  // Tick result and scan advance.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sel_next[i] = scan_ext != 5'(i);
    end
    frame_next = scan_row == RW'(ROWS - 1);
    scan_row_next = frame_next ? '0 : scan_row + RW'(1);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_kind   <= kind_t'(kind);
      s1_row    <= row;
      s1_value  <= value;
      s1_colour <= colour;
    end
  end

  // Stores, buffer select and scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < ROWS; r++) begin
          green_store[b][r] <= '0;
          red_store[b][r]   <= '0;
        end
      end
      shown    <= 1'b1;
      scan_row <= '0;
    end else if (s1_advance) begin
      if (s1_modify) begin
        if ((s1_colour & PLANE_RED) != 2'b00) begin
          red_store[!shown][rd_row] <= red_new;
        end
        if ((s1_colour & PLANE_GREEN) != 2'b00) begin
          green_store[!shown][rd_row] <= green_new;
        end
      end
      if (s1_kind == KIND_SWAP) begin
        shown <= !shown;
      end
      if (s1_tick) begin
        scan_row <= scan_row_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_advance && s1_tick) begin
      row_select    <= sel_next;
      green_columns <= reverse_byte(green_rd);
      red_columns   <= reverse_byte(red_rd);
      row_index     <= scan_ext[2:0];
      frame_end     <= frame_next;
    end
  end

  // A new result only follows a tick leaving the input register.
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_advance && s1_tick))
    else $error("result appeared without a scan tick");

  // Frame end marks the last row only.
  a_frame_end_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (row_index == 3'(ROWS - 1)))
    else $error("frame end on a row other than the last");

  // At most one row is driven.
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(~row_select) <= 1))
    else $error("more than one row selected");

  // The scan position stays inside the matrix.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    scan_row <= RW'(ROWS - 1))
    else $error("scan row out of range");

  // A swap request flips the shown buffer.
  a_swap_flips: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_kind == KIND_SWAP) |=> (shown != $past(shown)))
    else $error("swap did not change the shown buffer");

endmodule
